>>> src/vsac_pkg.sv
package vsac_pkg;

   // Default build values
   localparam int VSAC_WINDOW_DEPTH = 6;
   localparam int VSAC_MISS_LIMIT   = 2;
   localparam int VSAC_TICK_SECONDS = 10;

   // Oxygen thresholds in tenths of a percent
   localparam int OXY_MAX_TENTHS    = 999;
   localparam int OXY_LETHAL_TENTHS = 500;
   localparam int OXY_DANGER_TENTHS = 800;
   localparam int OXY_MAYBE_TENTHS  = 850;

   // Stored oxygen sample width (0..999)
   localparam int OXY_SAMPLE_W = 10;

   typedef enum logic [2:0] {
      ACT_ALL        = 3'd0,
      ACT_PULSE_BP   = 3'd1,
      ACT_PULSE_OXY  = 3'd2,
      ACT_PULSE_ONLY = 3'd3,
      ACT_BAD_COUNT  = 3'd4,
      ACT_UNPARSABLE = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      LV_NONE = 2'd0,
      LV_LOW  = 2'd1,
      LV_MED  = 2'd2,
      LV_HIGH = 2'd3
   } level_type;

   typedef enum logic [2:0] {
      RS_NORMAL      = 3'd0,
      RS_FAULT       = 3'd1,
      RS_LETHAL_LOW  = 3'd2,
      RS_LETHAL_HIGH = 3'd3,
      RS_DANGER_LOW  = 3'd4,
      RS_DANGER_HIGH = 3'd5,
      RS_MAYBE_HIGH  = 3'd6,
      RS_MAYBE_LOW   = 3'd7
   } reason_type;

   typedef enum logic [1:0] {
      SRC_PULSE = 2'd0,
      SRC_OXY   = 2'd1,
      SRC_BP    = 2'd2,
      SRC_NONE  = 2'd3
   } source_type;

   typedef struct packed {
      level_type  level;
      reason_type reason;
   } grade_type;

   localparam grade_type GRADE_NORMAL = '{level: LV_NONE, reason: RS_NORMAL};
   localparam grade_type GRADE_FAULT  = '{level: LV_LOW,  reason: RS_FAULT};

   // Per-word control for the oxygen window
   typedef struct packed {
      logic step;   // word moves into the result register
      logic read;   // oxygen value present
      logic miss;   // oxygen value absent
      logic clear;  // unparsable line, drop the window
   } oxy_ctrl_type;

endpackage

>>> src/vsac_vital_grade.sv
module vsac_vital_grade
   import vsac_pkg::*;
(
   input  logic signed [9:0] pulse_rate,
   input  logic signed [9:0] systolic,
   input  logic signed [9:0] diastolic,
   output grade_type         pulse_grade,
   output grade_type         pressure_grade
);

   // Pulse thresholds
   always_comb begin
      if (pulse_rate < 10'sd0 || pulse_rate > 10'sd210) begin
         pulse_grade = GRADE_FAULT;
      end else if (pulse_rate < 10'sd20) begin
         pulse_grade = '{level: LV_HIGH, reason: RS_LETHAL_LOW};
      end else if (pulse_rate > 10'sd170) begin
         pulse_grade = '{level: LV_HIGH, reason: RS_LETHAL_HIGH};
      end else if (pulse_rate < 10'sd40) begin
         pulse_grade = '{level: LV_MED, reason: RS_DANGER_LOW};
      end else if (pulse_rate > 10'sd130) begin
         pulse_grade = '{level: LV_MED, reason: RS_DANGER_HIGH};
      end else if (pulse_rate > 10'sd110) begin
         pulse_grade = '{level: LV_LOW, reason: RS_MAYBE_HIGH};
      end else begin
         pulse_grade = GRADE_NORMAL;
      end
   end

   // Blood pressure thresholds, either value can trip a grade
   always_comb begin
      if (systolic < 10'sd0 || diastolic < 10'sd0 ||
          systolic >= 10'sd230 || diastolic >= 10'sd150) begin
         pressure_grade = GRADE_FAULT;
      end else if (systolic < 10'sd50 || diastolic < 10'sd33) begin
         pressure_grade = '{level: LV_HIGH, reason: RS_LETHAL_LOW};
      end else if (systolic < 10'sd70 || diastolic < 10'sd40) begin
         pressure_grade = '{level: LV_MED, reason: RS_DANGER_LOW};
      end else if (systolic > 10'sd200 || diastolic > 10'sd120) begin
         pressure_grade = '{level: LV_MED, reason: RS_DANGER_HIGH};
      end else if (systolic > 10'sd150 || diastolic > 10'sd90) begin
         pressure_grade = '{level: LV_LOW, reason: RS_MAYBE_HIGH};
      end else begin
         pressure_grade = GRADE_NORMAL;
      end
   end

endmodule

>>> src/vsac_oxy_window.sv
module vsac_oxy_window
   import vsac_pkg::*;
#(
   parameter int WINDOW_DEPTH = VSAC_WINDOW_DEPTH,
   parameter int MISS_LIMIT   = VSAC_MISS_LIMIT
)
(
   input  logic               clock,
   input  logic               reset,
   input  oxy_ctrl_type       ctrl,
   input  logic signed [10:0] oxygen_tenths,
   output grade_type          grade_next
);

   localparam int SUM_W  = $clog2(OXY_MAX_TENTHS * WINDOW_DEPTH + 1);
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int MISS_W = $clog2(MISS_LIMIT + 2);

   // Mean thresholds scaled by the full window depth
   localparam logic [SUM_W-1:0] LETHAL_SUM = SUM_W'(OXY_LETHAL_TENTHS * WINDOW_DEPTH);
   localparam logic [SUM_W-1:0] DANGER_SUM = SUM_W'(OXY_DANGER_TENTHS * WINDOW_DEPTH);
   localparam logic [SUM_W-1:0] MAYBE_SUM  = SUM_W'(OXY_MAYBE_TENTHS * WINDOW_DEPTH);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(WINDOW_DEPTH);
   localparam logic [MISS_W-1:0] MISS_MAX  = MISS_W'(MISS_LIMIT);

   // Window as a shift line: tap 0 newest, last tap oldest once full
   logic [OXY_SAMPLE_W-1:0] win_ff [WINDOW_DEPTH];

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [MISS_W-1:0]       miss_ff, miss_in;
   grade_type               grade_ff, grade_in;

   logic                    full;
   logic                    oxy_ok;
   logic                    miss_over;
   logic [MISS_W-1:0]       miss_inc;
   logic                    push;
   logic [OXY_SAMPLE_W-1:0] push_val;
   logic [SUM_W-1:0]        sum_push;
   logic [CNT_W-1:0]        count_push;
   grade_type               mean_grade;

   assign full       = (count_ff == FULL_COUNT);
   assign oxy_ok     = !(oxygen_tenths < 11'sd0) && !(oxygen_tenths > 11'sd999);
   assign miss_inc   = miss_ff + MISS_W'(1);
   assign miss_over  = (miss_inc > MISS_MAX);

   // Running sum after a push, oldest entry leaves when full
   assign sum_push   = sum_ff + SUM_W'(push_val)
                       - (full ? SUM_W'(win_ff[WINDOW_DEPTH-1]) : '0);
   assign count_push = full ? count_ff : count_ff + CNT_W'(1);

   // Mean grade on the full window, compared as a sum
   always_comb begin
      if (sum_push < LETHAL_SUM) begin
         mean_grade = '{level: LV_HIGH, reason: RS_LETHAL_LOW};
      end else if (sum_push < DANGER_SUM) begin
         mean_grade = '{level: LV_MED, reason: RS_DANGER_LOW};
      end else if (sum_push < MAYBE_SUM) begin
         mean_grade = '{level: LV_LOW, reason: RS_MAYBE_LOW};
      end else begin
         mean_grade = GRADE_NORMAL;
      end
   end

   // Window update for one word
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      miss_in  = miss_ff;
      grade_in = grade_ff;
      push     = 1'b0;
      push_val = win_ff[0];
      if (ctrl.step) begin
         if (ctrl.clear || (ctrl.read && !oxy_ok) || (ctrl.miss && miss_over)) begin
            count_in = '0;
            sum_in   = '0;
            miss_in  = '0;
            grade_in = GRADE_FAULT;
         end else if (ctrl.read) begin
            miss_in  = '0;
            push     = 1'b1;
            push_val = oxygen_tenths[OXY_SAMPLE_W-1:0];
            count_in = count_push;
            sum_in   = sum_push;
            grade_in = full ? mean_grade : GRADE_NORMAL;
         end else if (ctrl.miss) begin
            miss_in = miss_inc;
            // repeat the newest sample; empty window only counts the miss
            if (count_ff != '0) begin
               push     = 1'b1;
               count_in = count_push;
               sum_in   = sum_push;
               if (full) begin
                  grade_in = mean_grade;
               end
            end
         end
      end
   end

   assign grade_next = grade_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         miss_ff  <= '0;
         grade_ff <= GRADE_NORMAL;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         miss_ff  <= miss_in;
         grade_ff <= grade_in;
      end
   end

   // Sample shift line, payload only
   always_ff @(posedge clock) begin
      if (push) begin
         win_ff[0] <= push_val;
         for (int i = 1; i < WINDOW_DEPTH; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("oxygen window count above depth");

   assert property (@(posedge clock) disable iff (reset) miss_ff <= MISS_MAX)
      else $error("missed read count above limit");

   assert property (@(posedge clock) disable iff (reset)
      (ctrl.step && ctrl.clear) |=> (count_ff == '0 && sum_ff == '0 && miss_ff == '0))
      else $error("window not cleared on unparsable line");

endmodule

>>> src/vsac_arbiter.sv
module vsac_arbiter
   import vsac_pkg::*;
(
   input  grade_type  pulse_grade,
   input  grade_type  oxygen_grade,
   input  grade_type  pressure_grade,
   output level_type  overall_level,
   output source_type report_source,
   output reason_type report_reason
);

   grade_type grades [3];

   assign grades[0] = pulse_grade;
   assign grades[1] = oxygen_grade;
   assign grades[2] = pressure_grade;

   // Highest level wins; a tie goes to the later source
   always_comb begin
      overall_level = LV_NONE;
      report_source = SRC_NONE;
      report_reason = RS_NORMAL;
      for (int i = 0; i < 3; i++) begin
         if (grades[i].level != LV_NONE && grades[i].level >= overall_level) begin
            overall_level = grades[i].level;
            report_reason = grades[i].reason;
            report_source = source_type'(2'(i));
         end
      end
   end

endmodule

>>> src/vital_sign_alarm_classifier.sv
// Vital sign alarm classifier.
// Input channel req_*: one monitor reading per word (action code, pulse,
// oxygen in tenths of a percent, systolic and diastolic pressure).
// Result channel rsp_*: one word per reading with the elapsed clock after
// the reading, the overall alarm level with its source and reason, and the
// three per-source levels.
// A reading sits in the input register and moves into the output register
// once that register is free; its result word stays valid there until the
// receiver takes it. Throughput: one reading per cycle while the receiver
// does not stall; the window sum, threshold compares and priority pick all
// resolve between the input and the output register.
// The oxygen window is a shift line of WINDOW_DEPTH samples with a running
// sum; its entries need no clearing, only the fill count and sum are reset.
// Reset clears the clock, window count and sum, miss count, and sets every
// source to no alarm; no pass over storage, the block is ready at once.
// When the receiver stalls the result holds, the input register still takes
// one more word, and req_ready drops until the result is taken.
module vital_sign_alarm_classifier
   import vsac_pkg::*;
#(
   parameter int WINDOW_DEPTH = VSAC_WINDOW_DEPTH,
   parameter int MISS_LIMIT   = VSAC_MISS_LIMIT,
   parameter int TICK_SECONDS = VSAC_TICK_SECONDS
)
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic signed [9:0]  req_pulse_rate,
   input  logic signed [10:0] req_oxygen_tenths,
   input  logic signed [9:0]  req_systolic,
   input  logic signed [9:0]  req_diastolic,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_clock_minutes,
   output logic [5:0]         rsp_clock_seconds,
   output logic [1:0]         rsp_overall_level,
   output logic [1:0]         rsp_report_source,
   output logic [2:0]         rsp_report_reason,
   output logic [1:0]         rsp_pulse_level,
   output logic [1:0]         rsp_oxygen_level,
   output logic [1:0]         rsp_pressure_level
);

   localparam logic [6:0] TICK      = 7'(TICK_SECONDS);
   localparam logic [6:0] SIXTY     = 7'd60;
   localparam logic [5:0] LAST_MIN  = 6'd59;

   // Input register
   logic               in_valid_ff;
   logic [2:0]         action_ff;
   logic signed [9:0]  pulse_ff;
   logic signed [10:0] oxygen_ff;
   logic signed [9:0]  systolic_ff;
   logic signed [9:0]  diastolic_ff;

   // Block state
   logic [5:0]         sec_ff, sec_in;
   logic [5:0]         min_ff, min_in;
   grade_type          pulse_grade_ff, pulse_grade_in;
   grade_type          bp_grade_ff, bp_grade_in;

   // Result register
   logic               rsp_valid_ff;
   logic [5:0]         rsp_min_ff;
   logic [5:0]         rsp_sec_ff;
   level_type          rsp_level_ff;
   source_type         rsp_source_ff;
   reason_type         rsp_reason_ff;
   level_type          rsp_pulse_lv_ff;
   level_type          rsp_oxy_lv_ff;
   level_type          rsp_bp_lv_ff;

   logic               advance;
   logic               req_take;
   action_type         action;
   oxy_ctrl_type       oxy_ctrl;
   logic               bp_present;
   logic               pulse_graded;
   logic [6:0]         sec_sum;

   grade_type          pulse_eval;
   grade_type          bp_eval;
   grade_type          oxy_grade_in;
   level_type          overall_in;
   source_type         source_in;
   reason_type         reason_in;

   // Handshake: the result register frees, the input word moves on
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         action_ff    <= req_action;
         pulse_ff     <= req_pulse_rate;
         oxygen_ff    <= req_oxygen_tenths;
         systolic_ff  <= req_systolic;
         diastolic_ff <= req_diastolic;
      end
   end

   // Action decode
   assign action = action_type'(action_ff);

   always_comb begin
      oxy_ctrl      = '0;
      oxy_ctrl.step = advance;
      bp_present    = 1'b0;
      pulse_graded  = 1'b1;
      unique case (action)
         ACT_ALL: begin
            oxy_ctrl.read = 1'b1;
            bp_present    = 1'b1;
         end
         ACT_PULSE_BP: begin
            oxy_ctrl.miss = 1'b1;
            bp_present    = 1'b1;
         end
         ACT_PULSE_OXY: begin
            oxy_ctrl.read = 1'b1;
         end
         ACT_PULSE_ONLY: begin
            oxy_ctrl.miss = 1'b1;
         end
         ACT_UNPARSABLE: begin
            oxy_ctrl.clear = 1'b1;
            pulse_graded   = 1'b0;
         end
         default: begin
            // bad field count and undefined codes
            pulse_graded = 1'b0;
         end
      endcase
   end

   vsac_vital_grade u_vital_grade (
      .pulse_rate     (pulse_ff),
      .systolic       (systolic_ff),
      .diastolic      (diastolic_ff),
      .pulse_grade    (pulse_eval),
      .pressure_grade (bp_eval)
   );

   vsac_oxy_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .MISS_LIMIT   (MISS_LIMIT)
   ) u_oxy_window (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (oxy_ctrl),
      .oxygen_tenths (oxygen_ff),
      .grade_next    (oxy_grade_in)
   );

   // Source grades kept across words
   always_comb begin
      pulse_grade_in = pulse_grade_ff;
      bp_grade_in    = bp_grade_ff;
      if (advance) begin
         pulse_grade_in = pulse_graded ? pulse_eval : GRADE_FAULT;
         if (bp_present) begin
            bp_grade_in = bp_eval;
         end
      end
   end

   // Elapsed clock, minutes wrap at the hour
   assign sec_sum = {1'b0, sec_ff} + TICK;

   always_comb begin
      sec_in = sec_ff;
      min_in = min_ff;
      if (advance) begin
         if (sec_sum >= SIXTY) begin
            sec_in = 6'(sec_sum - SIXTY);
            min_in = (min_ff == LAST_MIN) ? 6'd0 : min_ff + 6'd1;
         end else begin
            sec_in = sec_sum[5:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff         <= '0;
         min_ff         <= '0;
         pulse_grade_ff <= GRADE_NORMAL;
         bp_grade_ff    <= GRADE_NORMAL;
      end else begin
         sec_ff         <= sec_in;
         min_ff         <= min_in;
         pulse_grade_ff <= pulse_grade_in;
         bp_grade_ff    <= bp_grade_in;
      end
   end

   vsac_arbiter u_arbiter (
      .pulse_grade    (pulse_grade_in),
      .oxygen_grade   (oxy_grade_in),
      .pressure_grade (bp_grade_in),
      .overall_level  (overall_in),
      .report_source  (source_in),
      .report_reason  (reason_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_min_ff      <= min_in;
         rsp_sec_ff      <= sec_in;
         rsp_level_ff    <= overall_in;
         rsp_source_ff   <= source_in;
         rsp_reason_ff   <= reason_in;
         rsp_pulse_lv_ff <= pulse_grade_in.level;
         rsp_oxy_lv_ff   <= oxy_grade_in.level;
         rsp_bp_lv_ff    <= bp_grade_in.level;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_clock_minutes  = rsp_min_ff;
   assign rsp_clock_seconds  = rsp_sec_ff;
   assign rsp_overall_level  = rsp_level_ff;
   assign rsp_report_source  = rsp_source_ff;
   assign rsp_report_reason  = rsp_reason_ff;
   assign rsp_pulse_level    = rsp_pulse_lv_ff;
   assign rsp_oxygen_level   = rsp_oxy_lv_ff;
   assign rsp_pressure_level = rsp_bp_lv_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_level_ff == LV_NONE) == (rsp_source_ff == SRC_NONE)))
      else $error("report source disagrees with overall level");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_level_ff >= rsp_pulse_lv_ff && rsp_level_ff >= rsp_oxy_lv_ff &&
                        rsp_level_ff >= rsp_bp_lv_ff))
      else $error("overall level below a source level");

   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_valid_ff)
      else $error("word lost between input and result register");

   assert property (@(posedge clock) disable iff (reset)
      sec_ff < 6'd60 && min_ff < 6'd60)
      else $error("elapsed clock out of range");

endmodule

>>> bench/tb.sv
module tb;
   import vsac_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN  = VSAC_WINDOW_DEPTH;
   localparam int MISS = VSAC_MISS_LIMIT;
   localparam int TICK = VSAC_TICK_SECONDS;

   // Action codes outside the defined set, graded as a bad field count
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   localparam int RANDOM_READINGS = 600;
   localparam int SLOT_MAX        = 1024;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [9:0]  pulse;
      logic signed [10:0] oxygen;
      logic signed [9:0]  systolic;
      logic signed [9:0]  diastolic;
   } reading_type;

   typedef struct packed {
      logic [5:0] minutes;
      logic [5:0] seconds;
      level_type  overall;
      source_type source;
      reason_type reason;
      level_type  pulse;
      level_type  oxygen;
      level_type  pressure;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_action = '0;
   logic signed [9:0]  req_pulse_rate = '0;
   logic signed [10:0] req_oxygen_tenths = '0;
   logic signed [9:0]  req_systolic = '0;
   logic signed [9:0]  req_diastolic = '0;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [5:0] rsp_clock_minutes;
   logic [5:0] rsp_clock_seconds;
   logic [1:0] rsp_overall_level;
   logic [1:0] rsp_report_source;
   logic [2:0] rsp_report_reason;
   logic [1:0] rsp_pulse_level;
   logic [1:0] rsp_oxygen_level;
   logic [1:0] rsp_pressure_level;

   // Pending readings and expected results, each a FIFO over an array
   reading_type pending_readings [SLOT_MAX];
   verdict_type expected_verdicts [SLOT_MAX];
   int pending_count = 0;
   int pending_next  = 0;
   int expect_head   = 0;
   int expect_tail   = 0;

   int readings_total = 0;
   int readings_taken = 0;
   int results_seen   = 0;
   int mismatches     = 0;
   int oxy_trend      = 900;

   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   int req_gap   = 0;
   int req_calm  = 0;
   int rsp_hold  = 0;
   int rsp_calm  = 0;

   // Predicted block state
   int unsigned                clk_secs;
   logic [OXY_SAMPLE_W-1:0]    oxy_ring [WIN];
   int                         ring_head;
   int                         ring_fill;
   int                         ring_sum;
   int                         miss_run;
   level_type                  src_level  [0:2];
   reason_type                 src_reason [0:2];

   vital_sign_alarm_classifier i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_pulse_rate     (req_pulse_rate),
      .req_oxygen_tenths  (req_oxygen_tenths),
      .req_systolic       (req_systolic),
      .req_diastolic      (req_diastolic),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_clock_minutes  (rsp_clock_minutes),
      .rsp_clock_seconds  (rsp_clock_seconds),
      .rsp_overall_level  (rsp_overall_level),
      .rsp_report_source  (rsp_report_source),
      .rsp_report_reason  (rsp_report_reason),
      .rsp_pulse_level    (rsp_pulse_level),
      .rsp_oxygen_level   (rsp_oxygen_level),
      .rsp_pressure_level (rsp_pressure_level)
   );

   initial forever #10 clock = ~clock;

   // ---------------------------------------------------------------
   // Grading predictor
   // ---------------------------------------------------------------
   function automatic void set_grade(source_type s, level_type l, reason_type r);
      src_level[s]  = l;
      src_reason[s] = r;
   endfunction

   function automatic void grade_pulse(int p);
      if (p < 0 || p > 210)  set_grade(SRC_PULSE, LV_LOW,  RS_FAULT);
      else if (p < 20)       set_grade(SRC_PULSE, LV_HIGH, RS_LETHAL_LOW);
      else if (p > 170)      set_grade(SRC_PULSE, LV_HIGH, RS_LETHAL_HIGH);
      else if (p < 40)       set_grade(SRC_PULSE, LV_MED,  RS_DANGER_LOW);
      else if (p > 130)      set_grade(SRC_PULSE, LV_MED,  RS_DANGER_HIGH);
      else if (p > 110)      set_grade(SRC_PULSE, LV_LOW,  RS_MAYBE_HIGH);
      else                   set_grade(SRC_PULSE, LV_NONE, RS_NORMAL);
   endfunction

   function automatic void grade_pressure(int sy, int di);
      if (sy < 0 || di < 0 || sy >= 230 || di >= 150)
         set_grade(SRC_BP, LV_LOW, RS_FAULT);
      else if (sy < 50 || di < 33)   set_grade(SRC_BP, LV_HIGH, RS_LETHAL_LOW);
      else if (sy < 70 || di < 40)   set_grade(SRC_BP, LV_MED,  RS_DANGER_LOW);
      else if (sy > 200 || di > 120) set_grade(SRC_BP, LV_MED,  RS_DANGER_HIGH);
      else if (sy > 150 || di > 90)  set_grade(SRC_BP, LV_LOW,  RS_MAYBE_HIGH);
      else                           set_grade(SRC_BP, LV_NONE, RS_NORMAL);
   endfunction

   // Bad oxygen value, too many misses or unparsable line: empty the window, flag a fault
   function automatic void drop_window();
      miss_run  = 0;
      ring_head = 0;
      ring_fill = 0;
      ring_sum  = 0;
      set_grade(SRC_OXY, LV_LOW, RS_FAULT);
   endfunction

   // Mean compared exactly: sum against threshold times fill
   function automatic void grade_mean();
      if (ring_sum < OXY_LETHAL_TENTHS * ring_fill)
         set_grade(SRC_OXY, LV_HIGH, RS_LETHAL_LOW);
      else if (ring_sum < OXY_DANGER_TENTHS * ring_fill)
         set_grade(SRC_OXY, LV_MED, RS_DANGER_LOW);
      else if (ring_sum < OXY_MAYBE_TENTHS * ring_fill)
         set_grade(SRC_OXY, LV_LOW, RS_MAYBE_LOW);
      else
         set_grade(SRC_OXY, LV_NONE, RS_NORMAL);
   endfunction

   function automatic void push_sample(int v);
      if (ring_fill < WIN) begin
         oxy_ring[(ring_head + ring_fill) % WIN] = OXY_SAMPLE_W'(v);
         ring_fill++;
         ring_sum += v;
      end else begin
         ring_sum = ring_sum - int'(oxy_ring[ring_head]) + v;
         oxy_ring[ring_head] = OXY_SAMPLE_W'(v);
         ring_head = (ring_head + 1) % WIN;
      end
   endfunction

   function automatic void take_oxygen(int o);
      bit was_full;
      if (o < 0 || o > OXY_MAX_TENTHS) begin
         drop_window();
      end else begin
         miss_run = 0;
         was_full = (ring_fill == WIN);
         push_sample(o);
         if (was_full) grade_mean();
         else set_grade(SRC_OXY, LV_NONE, RS_NORMAL);
      end
   endfunction

   // Missed read repeats the newest sample; an empty window only counts
   function automatic void miss_oxygen();
      bit was_full;
      miss_run++;
      if (miss_run > MISS) begin
         drop_window();
      end else if (ring_fill > 0) begin
         was_full = (ring_fill == WIN);
         push_sample(int'(oxy_ring[(ring_head + ring_fill - 1) % WIN]));
         if (was_full) grade_mean();
      end
   endfunction

   function automatic verdict_type grade_reading(reading_type rd);
      verdict_type v;
      int p, o, sy, di;
      p  = $signed(rd.pulse);
      o  = $signed(rd.oxygen);
      sy = $signed(rd.systolic);
      di = $signed(rd.diastolic);
      clk_secs = (clk_secs + TICK) % 3600;
      case (rd.action)
         ACT_ALL: begin
            grade_pulse(p);
            take_oxygen(o);
            grade_pressure(sy, di);
         end
         ACT_PULSE_BP: begin
            grade_pulse(p);
            grade_pressure(sy, di);
            miss_oxygen();
         end
         ACT_PULSE_OXY: begin
            grade_pulse(p);
            take_oxygen(o);
         end
         ACT_PULSE_ONLY: begin
            miss_oxygen();
            grade_pulse(p);
         end
         ACT_UNPARSABLE: begin
            set_grade(SRC_PULSE, LV_LOW, RS_FAULT);
            drop_window();
         end
         default: set_grade(SRC_PULSE, LV_LOW, RS_FAULT);
      endcase

      // Highest level wins, a tie goes to the later source
      v.overall = LV_NONE;
      v.source  = SRC_NONE;
      v.reason  = RS_NORMAL;
      for (int i = 0; i < 3; i++) begin
         if (src_level[i] != LV_NONE && src_level[i] >= v.overall) begin
            v.overall = src_level[i];
            v.reason  = src_reason[i];
            v.source  = source_type'(2'(i));
         end
      end
      v.minutes  = 6'((clk_secs / 60) % 60);
      v.seconds  = 6'(clk_secs % 60);
      v.pulse    = src_level[SRC_PULSE];
      v.oxygen   = src_level[SRC_OXY];
      v.pressure = src_level[SRC_BP];
      return v;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic add_word(reading_type rd);
      pending_readings[pending_count] = rd;
      pending_count++;
   endtask

   task automatic add_reading(logic [2:0] a, int p, int o, int sy, int di);
      reading_type rd;
      rd.action    = a;
      rd.pulse     = 10'(p);
      rd.oxygen    = 11'(o);
      rd.systolic  = 10'(sy);
      rd.diastolic = 10'(di);
      add_word(rd);
   endtask

   // Mostly well-formed readings around a drifting oxygen trend
   function automatic reading_type draw_reading();
      reading_type rd;
      int r, o;
      r = int'($urandom_range(0, 99));
      if (r < 44)      rd.action = ACT_ALL;
      else if (r < 58) rd.action = ACT_PULSE_OXY;
      else if (r < 72) rd.action = ACT_PULSE_BP;
      else if (r < 84) rd.action = ACT_PULSE_ONLY;
      else if (r < 90) rd.action = ACT_BAD_COUNT;
      else if (r < 93) rd.action = ACT_UNPARSABLE;
      else             rd.action = 3'($urandom_range(0, 7));

      if ($urandom_range(0, 99) < 88) rd.pulse = 10'($urandom_range(0, 225));
      else                            rd.pulse = 10'($urandom);

      if ($urandom_range(0, 99) < 95) begin
         o = oxy_trend + int'($urandom_range(0, 120)) - 60;
         if (o < 0) o = 0;
         if (o > OXY_MAX_TENTHS) o = OXY_MAX_TENTHS;
         rd.oxygen = 11'(o);
      end else begin
         rd.oxygen = 11'($urandom);
      end

      if ($urandom_range(0, 99) < 90) rd.systolic = 10'($urandom_range(30, 240));
      else                            rd.systolic = 10'($urandom);
      if ($urandom_range(0, 99) < 90) rd.diastolic = 10'($urandom_range(20, 160));
      else                            rd.diastolic = 10'($urandom);
      return rd;
   endfunction

   // Idle length: mostly none or short, sometimes long
   function automatic int draw_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 55) return 0;
      if (r < 90) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 30));
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
   endtask

   task automatic check_field(int idx, string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                   idx, name, got, want));
   endtask

   // ---------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------
   always @(negedge clock) begin : req_drive
      reading_type rd;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (pending_next < pending_count) begin
            rd = pending_readings[pending_next];
            pending_next++;
            req_action        <= rd.action;
            req_pulse_rate    <= rd.pulse;
            req_oxygen_tenths <= rd.oxygen;
            req_systolic      <= rd.systolic;
            req_diastolic     <= rd.diastolic;
            req_valid         <= 1'b1;
            if (req_calm > 0) begin
               req_calm <= req_calm - 1;
               req_gap  <= 0;
            end else begin
               req_gap <= draw_gap();
               if ($urandom_range(0, 39) == 0) req_calm <= int'($urandom_range(20, 60));
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Response ready driver
   // ---------------------------------------------------------------
   always @(negedge clock) begin : rsp_drive
      int g;
      if (reset) begin
         rsp_ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         g = 0;
         if (rsp_calm > 0) begin
            rsp_calm <= rsp_calm - 1;
         end else if (rsp_taken || $urandom_range(0, 7) == 0) begin
            g = draw_gap();
            if ($urandom_range(0, 39) == 0) rsp_calm <= int'($urandom_range(30, 150));
         end
         rsp_ready <= (g == 0);
         rsp_hold  <= (g > 0) ? g - 1 : 0;
      end
   end

   // ---------------------------------------------------------------
   // Monitor: predict on each accepted word, check each result word
   // ---------------------------------------------------------------
   always @(posedge clock) begin : watch
      reading_type rd;
      verdict_type got;
      verdict_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;

         if (req_valid && req_ready) begin
            rd.action    = req_action;
            rd.pulse     = req_pulse_rate;
            rd.oxygen    = req_oxygen_tenths;
            rd.systolic  = req_systolic;
            rd.diastolic = req_diastolic;
            expected_verdicts[expect_tail] = grade_reading(rd);
            expect_tail++;
            readings_taken++;
         end

         if (rsp_valid && rsp_ready) begin
            got.minutes  = rsp_clock_minutes;
            got.seconds  = rsp_clock_seconds;
            got.overall  = level_type'(rsp_overall_level);
            got.source   = source_type'(rsp_report_source);
            got.reason   = reason_type'(rsp_report_reason);
            got.pulse    = level_type'(rsp_pulse_level);
            got.oxygen   = level_type'(rsp_oxygen_level);
            got.pressure = level_type'(rsp_pressure_level);
            if (expect_head == expect_tail) begin
               report_mismatch($sformatf("result %0d arrived with nothing pending",
                                         results_seen));
            end else begin
               want = expected_verdicts[expect_head];
               expect_head++;
               check_field(results_seen, "clock_minutes", got.minutes, want.minutes);
               check_field(results_seen, "clock_seconds", got.seconds, want.seconds);
               check_field(results_seen, "overall_level", got.overall, want.overall);
               check_field(results_seen, "report_source", got.source, want.source);
               check_field(results_seen, "report_reason", got.reason, want.reason);
               check_field(results_seen, "pulse_level", got.pulse, want.pulse);
               check_field(results_seen, "oxygen_level", got.oxygen, want.oxygen);
               check_field(results_seen, "pressure_level", got.pressure, want.pressure);
            end
            results_seen++;
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequence: fill the queue, release reset, wait for the last result
   // ---------------------------------------------------------------
   initial begin : stimulus
      int n;
      clk_secs  = 0;
      ring_head = 0;
      ring_fill = 0;
      ring_sum  = 0;
      miss_run  = 0;
      for (n = 0; n < WIN; n++) oxy_ring[n] = '0;
      for (n = 0; n < 3; n++) begin
         src_level[n]  = LV_NONE;
         src_reason[n] = RS_NORMAL;
      end

      // field extremes
      add_reading(ACT_ALL, -512, -1024, -512, -512);
      add_reading(ACT_ALL, 511, 1023, 511, 511);
      // misses on an empty window, third one faults
      add_reading(ACT_PULSE_ONLY, 0, 0, 0, 0);
      add_reading(ACT_PULSE_ONLY, 19, 0, 0, 0);
      add_reading(ACT_PULSE_ONLY, 20, 0, 0, 0);
      // fill the window while walking pulse and pressure thresholds
      add_reading(ACT_ALL, 39, 999, 49, 100);
      add_reading(ACT_ALL, 40, 0, 50, 32);
      add_reading(ACT_PULSE_OXY, 110, 500, 0, 0);
      add_reading(ACT_PULSE_BP, 111, 0, 69, 33);
      add_reading(ACT_ALL, 130, 499, 70, 39);
      add_reading(ACT_ALL, 131, 850, 70, 40);
      // full window, mean graded
      add_reading(ACT_ALL, 170, 849, 200, 120);
      add_reading(ACT_ALL, 171, 800, 201, 121);
      add_reading(ACT_ALL, 210, 799, 150, 90);
      add_reading(ACT_ALL, 211, 850, 151, 91);
      // misses on a full window until the limit clears it
      add_reading(ACT_PULSE_BP, 100, 0, 229, 149);
      add_reading(ACT_PULSE_ONLY, 100, 0, 0, 0);
      add_reading(ACT_PULSE_ONLY, 100, 0, 0, 0);
      // pressure out of range on each side
      add_reading(ACT_ALL, 100, 900, 230, 80);
      add_reading(ACT_ALL, 100, 900, 120, 150);
      // malformed lines, undefined actions and out-of-range values
      add_reading(ACT_BAD_COUNT, 100, 900, 120, 80);
      add_reading(ACT_UNPARSABLE, 100, 900, 120, 80);
      add_reading(ACT_SPARE_6, 100, 900, 120, 80);
      add_reading(ACT_SPARE_7, 100, 900, 120, 80);
      add_reading(ACT_PULSE_OXY, -1, 1000, 0, 0);

      for (n = 0; n < RANDOM_READINGS; n++) begin
         if (n % 25 == 0) oxy_trend = int'($urandom_range(350, 999));
         add_word(draw_reading());
      end
      readings_total = pending_count;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (readings_taken < readings_total || expect_head != expect_tail)
         @(negedge clock);
      // leave room for a stray extra word
      repeat (8) @(posedge clock);

      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

>>> files.f
src/vsac_pkg.sv
src/vsac_vital_grade.sv
src/vsac_oxy_window.sv
src/vsac_arbiter.sv
src/vital_sign_alarm_classifier.sv
bench/tb.sv
